// ----- rtl/bti_pkg.sv -----
// bti_pkg: shared types and constants of the bilinear table interpolator.
// Used by bilinear_table_interpolator_top; depends on nothing else.
`timescale 1ns / 1ps
package bti_pkg;

    localparam int COMP_LEN_DEF = 16;
    localparam int AGE_LEN_DEF  = 64;

    localparam int CFG_W = 34;

    // register indexes of the configuration port
    typedef enum logic [1:0] {
        CFG_COMP_FLOOR   = 2'd0,
        CFG_COMP_CEILING = 2'd1,
        CFG_AGE_FLOOR    = 2'd2,
        CFG_AGE_CEILING  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_LOAD_COMP = 2'd0,
        KIND_LOAD_AGE  = 2'd1,
        KIND_LOAD_GRID = 2'd2,
        KIND_QUERY     = 2'd3
    } t_kind;

    localparam logic [31:0] COMP_FLOOR_RST   = 32'd42950;
    localparam logic [31:0] COMP_CEILING_RST = 32'd42949673;
    localparam logic [33:0] AGE_FLOOR_RST    = 34'd10000000;
    localparam logic [33:0] AGE_CEILING_RST  = 34'd10000000000;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  row;
        logic [5:0]  col;
        logic [33:0] load_value;
        logic [31:0] composition;
        logic [33:0] age_years;
    } t_item;

    typedef struct packed {
        logic [31:0] radius;
        logic [3:0]  comp_cell;
        logic [5:0]  age_cell;
    } t_result;

endpackage

// ----- rtl/bilinear_table_interpolator_top.sv -----
// bilinear_table_interpolator_top: axis/grid tables, clamp, search, divide and blend sequencer.
// Depends on bti_pkg.
`timescale 1ns / 1ps
// A transaction with kind load writes one axis or grid entry in the cycle it is accepted and
// gives no result; busy stays low. Each axis search step of a query waits for a registered
// table read. An offset at or outside its cell bounds needs no division; one strictly inside
// its cell goes through a restoring divider that yields a 16-bit quotient. The six blend
// products share one 32x17 multiplier. busy is high throughout a query and drops in the cycle
// that shows the result, so a new transaction can be taken then. The result is shown for one
// cycle only and must be taken then. Tables hold garbage until written.
module bilinear_table_interpolator_top
    import bti_pkg::*;
#(
    parameter int COMP_LEN = COMP_LEN_DEF,
    parameter int AGE_LEN  = AGE_LEN_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_item            i_item,
    output logic             o_done,
    output t_result          o_result,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(COMP_LEN);
    localparam int AW = $clog2(AGE_LEN);
    localparam int IW = (CW > AW) ? CW : AW;
    localparam int GD = COMP_LEN * AGE_LEN;
    localparam int GW = $clog2(GD);
    localparam logic [IW:0] COMP_LIM = (IW + 1)'(COMP_LEN - 2);
    localparam logic [IW:0] AGE_LIM  = (IW + 1)'(AGE_LEN - 2);

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLAMP, ST_SRCH, ST_SCMP, ST_LO_RD, ST_HI_RD, ST_DIV_SET,
        ST_DIV, ST_OFF_DONE, ST_GRD, ST_MUL
    } t_state;

    t_state      r_state;
    logic [31:0] r_comp_floor, r_comp_ceiling;
    logic [33:0] r_age_floor, r_age_ceiling;
    logic [31:0] r_comp_in, r_c;
    logic [33:0] r_age_in, r_a;
    logic        r_axis;
    logic [IW-1:0] r_idx;
    logic [CW-1:0] r_xi;
    logic [AW-1:0] r_yi;
    logic [33:0] r_lo, r_rem, r_den;
    logic [15:0] r_q;
    logic [4:0]  r_cnt;
    logic [16:0] r_d, r_dx, r_dy;
    logic [2:0]  r_k;
    logic [31:0] r_g [4];
    logic [31:0] r_c0, r_c1;
    logic [48:0] r_prod, r_acc;

    logic [31:0] comp_mem [COMP_LEN];
    logic [33:0] age_mem  [AGE_LEN];
    logic [31:0] grid_mem [GD];
    logic [31:0] r_comp_rd, r_grid_rd;
    logic [33:0] r_age_rd;

    // ---------------------------------------------------------------- load side
    logic          accept;
    logic [7:0]    row8;
    logic [8:0]    col9;
    logic          row_ok, col_ok;
    logic [GW-1:0] load_gaddr;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign row8   = 8'(i_item.row);
    assign col9   = 9'(i_item.col);
    assign row_ok = 32'(row8) < 32'(COMP_LEN);
    assign col_ok = 32'(col9) < 32'(AGE_LEN);
    assign load_gaddr = GW'(GW'(row8[CW-1:0]) * GW'(AGE_LEN)) + GW'(col9[AW-1:0]);

    // ---------------------------------------------------------------- read addressing
    logic [IW-1:0] rd_idx;
    logic [CW-1:0] gx;
    logic [AW-1:0] gy;
    logic [GW-1:0] rd_gaddr;
    logic [33:0]   axis_rd, cur_val;
    logic [IW:0]   lim;

    assign rd_idx   = (r_state == ST_LO_RD) ? r_idx : r_idx + IW'(1);
    assign gx       = r_xi + CW'(r_k[0]);
    assign gy       = r_yi + AW'(r_k[1]);
    assign rd_gaddr = GW'(GW'(gx) * GW'(AGE_LEN)) + GW'(gy);
    assign axis_rd  = r_axis ? r_age_rd : {2'b00, r_comp_rd};
    assign cur_val  = r_axis ? r_a : {2'b00, r_c};
    assign lim      = r_axis ? AGE_LIM : COMP_LIM;

    always_ff @(posedge i_clk) begin
        if (accept && i_item.kind == KIND_LOAD_COMP && row_ok) begin
            comp_mem[row8[CW-1:0]] <= i_item.load_value[31:0];
        end
        r_comp_rd <= comp_mem[rd_idx[CW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_item.kind == KIND_LOAD_AGE && col_ok) begin
            age_mem[col9[AW-1:0]] <= i_item.load_value;
        end
        r_age_rd <= age_mem[rd_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_item.kind == KIND_LOAD_GRID && row_ok && col_ok) begin
            grid_mem[load_gaddr] <= i_item.load_value[31:0];
        end
        r_grid_rd <= grid_mem[rd_gaddr];
    end

    // ---------------------------------------------------------------- clamp
    logic [31:0] c_lo;
    logic [33:0] a_lo;
    assign c_lo = (r_comp_in < r_comp_floor) ? r_comp_floor : r_comp_in;
    assign a_lo = (r_age_in < r_age_floor) ? r_age_floor : r_age_in;

    // ---------------------------------------------------------------- divider step
    logic [34:0] rem_sh;
    logic        rem_ge;
    assign rem_sh = {r_rem, 1'b0};
    assign rem_ge = rem_sh >= {1'b0, r_den};

    // ---------------------------------------------------------------- shared multiplier
    logic [31:0] mul_a;
    logic [16:0] mul_d, mul_f;
    logic [48:0] pair_sum;
    logic [31:0] pair_rnd;
    logic [2:0]  k_prev;

    always_comb begin
        case (r_k)
            3'd0:    mul_a = r_g[0];
            3'd1:    mul_a = r_g[1];
            3'd2:    mul_a = r_g[2];
            3'd3:    mul_a = r_g[3];
            3'd4:    mul_a = r_c0;
            default: mul_a = r_c1;
        endcase
    end
    assign mul_d    = (r_k < 3'd4) ? r_dx : r_dy;
    assign mul_f    = r_k[0] ? mul_d : ONE_Q16 - mul_d;
    assign pair_sum = r_acc + r_prod;
    assign pair_rnd = 32'((pair_sum + 49'd32768) >> 16);
    assign k_prev   = r_k - 3'd1;

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            o_done         <= 1'b0;
            r_comp_floor   <= COMP_FLOOR_RST;
            r_comp_ceiling <= COMP_CEILING_RST;
            r_age_floor    <= AGE_FLOOR_RST;
            r_age_ceiling  <= AGE_CEILING_RST;
        end else begin
            // last blend step: the final pair sum is ready
            o_done <= (r_state == ST_MUL) && (r_k == 3'd6);
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_COMP_FLOOR:   r_comp_floor   <= i_cfg_data[31:0];
                    CFG_COMP_CEILING: r_comp_ceiling <= i_cfg_data[31:0];
                    CFG_AGE_FLOOR:    r_age_floor    <= i_cfg_data;
                    CFG_AGE_CEILING:  r_age_ceiling  <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept && i_item.kind == KIND_QUERY) begin
                        r_comp_in <= i_item.composition;
                        r_age_in  <= i_item.age_years;
                        r_state   <= ST_CLAMP;
                    end
                end
                ST_CLAMP: begin
                    r_c     <= (c_lo > r_comp_ceiling) ? r_comp_ceiling : c_lo;
                    r_a     <= (a_lo > r_age_ceiling) ? r_age_ceiling : a_lo;
                    r_axis  <= 1'b0;
                    r_idx   <= '0;
                    r_state <= ST_SRCH;
                end
                ST_SRCH: begin
                    // read of entry idx+1 is issued here when a step remains
                    r_state <= ({1'b0, r_idx} < lim) ? ST_SCMP : ST_LO_RD;
                end
                ST_SCMP: begin
                    if (cur_val < axis_rd) begin
                        r_state <= ST_LO_RD;
                    end else begin
                        r_idx   <= r_idx + IW'(1);
                        r_state <= ST_SRCH;
                    end
                end
                ST_LO_RD: r_state <= ST_HI_RD;
                ST_HI_RD: begin
                    r_lo    <= axis_rd;
                    r_state <= ST_DIV_SET;
                end
                ST_DIV_SET: begin
                    if (axis_rd <= r_lo || cur_val <= r_lo) begin
                        r_d     <= '0;
                        r_state <= ST_OFF_DONE;
                    end else if (cur_val >= axis_rd) begin
                        r_d     <= ONE_Q16;
                        r_state <= ST_OFF_DONE;
                    end else begin
                        r_rem   <= cur_val - r_lo;
                        r_den   <= axis_rd - r_lo;
                        r_cnt   <= 5'd16;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_rem <= rem_ge ? 34'(rem_sh - {1'b0, r_den}) : 34'(rem_sh);
                    r_q   <= {r_q[14:0], rem_ge};
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd1) begin
                        r_d     <= {1'b0, r_q[14:0], rem_ge};
                        r_state <= ST_OFF_DONE;
                    end
                end
                ST_OFF_DONE: begin
                    if (!r_axis) begin
                        r_dx    <= r_d;
                        r_xi    <= r_idx[CW-1:0];
                        r_axis  <= 1'b1;
                        r_idx   <= '0;
                        r_state <= ST_SRCH;
                    end else begin
                        r_dy    <= r_d;
                        r_yi    <= r_idx[AW-1:0];
                        r_k     <= '0;
                        r_state <= ST_GRD;
                    end
                end
                ST_GRD: begin
                    // corner k is addressed at step k and captured from the registered read in the cycle after
                    if (r_k != 3'd0) begin
                        r_g[k_prev[1:0]] <= r_grid_rd;
                    end
                    if (r_k == 3'd4) begin
                        r_k     <= '0;
                        r_state <= ST_MUL;
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                ST_MUL: begin
                    r_prod <= 49'(mul_a) * 49'(mul_f);
                    r_k    <= r_k + 3'd1;
                    if (r_k != 3'd0) begin
                        if (!k_prev[0]) begin
                            r_acc <= r_prod;
                        end else begin
                            case (k_prev)
                                3'd1: r_c0 <= pair_rnd;
                                3'd3: r_c1 <= pair_rnd;
                                default: begin
                                    o_result.radius    <= pair_rnd;
                                    o_result.comp_cell <= 4'(r_xi);
                                    o_result.age_cell  <= 6'(r_yi);
                                    r_state            <= ST_IDLE;
                                end
                            endcase
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // ---------------------------------------------------------------- checks
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while a query is still running");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    a_done_from_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state) == ST_MUL)
        else $error("result strobe not issued by the blend step");

endmodule
